// File: hw/rtl/psp_pkg.sv
// Package for the polar scan to pixel block: payload structs, register
// indexes and the CORDIC arctangent table. No dependencies.
package psp_pkg;

  localparam int unsigned PIX_W   = 9;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  typedef enum logic [1:0] {
    CFG_START_ANGLE = 2'd0,
    CFG_ANGLE_STEP  = 2'd1,
    CFG_MAX_RANGE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] range_sample;
    logic        start_of_scan;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;
  } out_t;

  typedef struct packed {
    logic [15:0]        start_angle;
    logic signed [15:0] angle_step;
    logic [15:0]        max_range;
  } cfg_t;

  // one plotted beam, as handed from the front to the back
  typedef struct packed {
    logic [RANGE_W-1:0] range_sample;
    logic [31:0]        phase;
    logic [RANGE_W-1:0] max_range;
  } job_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    unique case (i)
      4'd0:  v = 32'd536870912;
      4'd1:  v = 32'd316933406;
      4'd2:  v = 32'd167458907;
      4'd3:  v = 32'd85004756;
      4'd4:  v = 32'd42667331;
      4'd5:  v = 32'd21354465;
      4'd6:  v = 32'd10679838;
      4'd7:  v = 32'd5340245;
      4'd8:  v = 32'd2670163;
      4'd9:  v = 32'd1335087;
      4'd10: v = 32'd667544;
      4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;
      4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;
      4'd15: v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/psp_queue.sv
// Short register queue between the front and the back of the converter.
// Depends on nothing but its type parameter.
module psp_queue #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// File: hw/rtl/psp_front.sv
// Front end: takes beam transactions, tracks the beam angle, drops samples
// beyond the maximum range and queues the rest. Uses psp_pkg.
module psp_front #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psp_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  psp_pkg::in_t  data_i,
  output logic          q_push_o,
  output psp_pkg::job_t job_o
);
  localparam int unsigned SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int unsigned SHR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  logic [ANGLE_BITS-1:0] beam_q, beam_d, cur_angle, start_al, step_al;
  logic signed [39:0]    step_ext;
  logic [39:0]           start_ext;

  always_comb begin
    step_ext  = 40'(cfg_i.angle_step);
    start_ext = 40'(cfg_i.start_angle);
    if (ANGLE_BITS >= 16) begin
      step_al  = ANGLE_BITS'(step_ext <<< SHL);
      start_al = ANGLE_BITS'(start_ext << SHL);
    end else begin
      step_al  = ANGLE_BITS'(step_ext >>> SHR);
      start_al = ANGLE_BITS'(start_ext >> SHR);
    end
    cur_angle = data_i.start_of_scan ? start_al : beam_q;
    beam_d    = accept_i ? cur_angle + step_al : beam_q;
  end

  assign q_push_o           = accept_i && (data_i.range_sample <= cfg_i.max_range);
  assign job_o.range_sample = data_i.range_sample;
  assign job_o.max_range    = cfg_i.max_range;
  assign job_o.phase        = {cur_angle, {(32 - ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q <= '0;
    end else begin
      beam_q <= beam_d;
    end
  end
endmodule

// File: hw/rtl/psp_back.sv
// Back end: iterative CORDIC, scaling multiply, bit-serial rounding divide
// for row and column side by side, saturation and the result register.
// Uses psp_pkg.
module psp_back #(
  parameter int unsigned IMAGE_SIZE = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  psp_pkg::job_t job_i,
  output logic          q_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output psp_pkg::out_t data_o
);
  localparam int unsigned HALF = IMAGE_SIZE / 2;
  localparam int unsigned QW   = $clog2(IMAGE_SIZE) + 1;
  localparam int unsigned NW   = 51 + $clog2(IMAGE_SIZE);
  localparam int unsigned CW   = $clog2(QW);
  localparam int unsigned PW   = QW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]         st_q, st_d;
  logic [3:0]         it_q;
  logic [CW-1:0]      dc_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q, mzero_q;
  logic [15:0]        rng_q, max_q;
  logic [49:0]        pr_q, pc_q;
  logic               nr_q, nc_q;
  logic [NW-1:0]      rr_q, rc_q, den_q;
  logic [QW-1:0]      qr_q, qc_q;
  logic               valid_q;
  psp_pkg::out_t      out_q;

  logic signed [33:0] tx, ty, sx, sy;
  logic [33:0]        ax, ay;
  logic [31:0]        pf;
  logic               fl, write_out;
  logic [NW-1:0]      half_den;
  logic signed [PW-1:0] pos_r, pos_c;
  psp_pkg::out_t      res;

  function automatic logic [PW-1:0] sat_pos(input logic [QW-1:0] q, input logic neg,
                                             input logic zero);
    logic signed [PW-1:0] p;
    p = zero ? PW'(HALF) : (neg ? PW'(HALF) - PW'(q) : PW'(HALF) + PW'(q));
    if (p < 0) begin
      p = '0;
    end else if (p > PW'(IMAGE_SIZE - 1)) begin
      p = PW'(IMAGE_SIZE - 1);
    end
    return p;
  endfunction

  always_comb begin
    tx = flip_q ? -x_q : x_q;
    ty = flip_q ? -y_q : y_q;
    ax = tx[33] ? 34'(-tx) : 34'(tx);
    ay = ty[33] ? 34'(-ty) : 34'(ty);
    sx = x_q >>> it_q;
    sy = y_q >>> it_q;
    fl = job_i.phase[31] ^ job_i.phase[30];
    pf = {job_i.phase[31] ^ fl, job_i.phase[30:0]};
    half_den = NW'({max_q, 29'd0});
    pos_r = sat_pos(qr_q, nr_q, mzero_q);
    pos_c = sat_pos(qc_q, nc_q, mzero_q);
    res.pixel_row = psp_pkg::PIX_W'(pos_r);
    res.pixel_col = psp_pkg::PIX_W'(pos_c);
    write_out = (st_q == ST_DONE) && (!valid_q || pop_i);
    q_pop_o   = (st_q == ST_IDLE) && !q_empty_i;
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (!q_empty_i) st_d = ST_ROT;
      ST_ROT:  if (it_q == 4'(psp_pkg::CORDIC_STEPS - 1)) st_d = ST_MUL;
      ST_MUL:  st_d = ST_PREP;
      ST_PREP: st_d = ST_DIV;
      ST_DIV:  if (dc_q == '0) st_d = ST_DONE;
      ST_DONE: if (write_out) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (write_out) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_out) begin
      out_q <= res;
    end
    unique case (st_q)
      ST_IDLE: begin
        x_q     <= psp_pkg::CORDIC_START;
        y_q     <= '0;
        z_q     <= 34'(signed'(pf));
        flip_q  <= fl;
        it_q    <= '0;
        rng_q   <= job_i.range_sample;
        max_q   <= job_i.max_range;
        mzero_q <= (job_i.max_range == '0);
      end
      ST_ROT: begin
        if (!z_q[33]) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - 34'(psp_pkg::atan_turn(it_q));
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + 34'(psp_pkg::atan_turn(it_q));
        end
        it_q <= it_q + 1'b1;
      end
      ST_MUL: begin
        pr_q <= 50'(rng_q) * 50'(ax);
        pc_q <= 50'(rng_q) * 50'(ay);
        nr_q <= tx[33];
        nc_q <= ty[33];
      end
      ST_PREP: begin
        rr_q  <= NW'(pr_q) * NW'(HALF) + half_den;
        rc_q  <= NW'(pc_q) * NW'(HALF) + half_den;
        den_q <= NW'({max_q, 30'd0}) << (QW - 1);
        dc_q  <= CW'(QW - 1);
        qr_q  <= '0;
        qc_q  <= '0;
      end
      ST_DIV: begin
        if (rr_q >= den_q) begin
          rr_q <= rr_q - den_q;
          qr_q <= {qr_q[QW-2:0], 1'b1};
        end else begin
          qr_q <= {qr_q[QW-2:0], 1'b0};
        end
        if (rc_q >= den_q) begin
          rc_q <= rc_q - den_q;
          qc_q <= {qc_q[QW-2:0], 1'b1};
        end else begin
          qc_q <= {qc_q[QW-2:0], 1'b0};
        end
        den_q <= den_q >> 1;
        dc_q  <= dc_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign empty_o = !valid_q;
  assign data_o  = out_q;
endmodule

// File: hw/rtl/polar_scan_to_pixel.sv
// Top level of the polar scan to pixel converter: configuration registers,
// front end, job queue and back end. Uses psp_pkg, psp_front, psp_queue, psp_back.
//
//  channel  direction  handshake            payload
//  input    in         push_i / full_o      in_data_i  (psp_pkg::in_t)
//  result   out        empty_o / pop_i      out_data_o (psp_pkg::out_t)
//  config   in         cfg_valid_i / ready  cfg_index_i, cfg_data_i
//
// In the back end a plotted beam passes idle, 16 CORDIC iterations, multiply,
// prepare, log2(IMAGE_SIZE)+1 divide steps and done, where it waits while the
// result register is full; the back end takes a new beam only back in idle.
// A beam beyond max_range is accepted by the front end and yields nothing.
// The two-entry queue lets the front keep taking beams while the back works, until it is full.
// Reset clears start angle, angle step, beam angle, queue and result flag, and sets max_range to 0xFFFF.
module polar_scan_to_pixel #(
  parameter int unsigned IMAGE_SIZE = 512,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  psp_pkg::in_t  in_data_i,
  output logic          empty_o,
  input  logic          pop_i,
  output psp_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  psp_pkg::cfg_t cfg_q;
  psp_pkg::job_t push_job, pop_job;
  logic          accept, q_push, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= '0;
      cfg_q.max_range   <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        psp_pkg::CFG_START_ANGLE: cfg_q.start_angle <= cfg_data_i;
        psp_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data_i;
        psp_pkg::CFG_MAX_RANGE:   cfg_q.max_range   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  psp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .data_i   (in_data_i),
    .q_push_o (q_push),
    .job_o    (push_job)
  );

  psp_queue #(.T(psp_pkg::job_t), .DEPTH(2)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (push_job),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .data_o  (pop_job),
    .empty_o (q_empty)
  );

  psp_back #(.IMAGE_SIZE(IMAGE_SIZE)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .job_i     (pop_job),
    .q_pop_o   (q_pop),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .data_o    (out_data_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> accept) else $error("queue push without transaction");

  a_drop_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.range_sample > cfg_q.max_range)) |-> !q_push)
    else $error("out-of-range beam queued");
endmodule
